### hw/rtl/battery_presence_debounce_classifier_unit_macros.svh
// ----------------------------------------------------------------------------
// battery presence debounce classifier assertion macros
// shared concurrent assertion forms, sampled on clk_i, held off by rst_ni
// ----------------------------------------------------------------------------
`ifndef BATTERY_PRESENCE_DEBOUNCE_CLASSIFIER_UNIT_MACROS_SVH
`define BATTERY_PRESENCE_DEBOUNCE_CLASSIFIER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define BPDC_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bpdc assertion failed");

// next-cycle implication
`define BPDC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bpdc assertion failed");

`else

`define BPDC_ASSERT_IMPLY(lbl, ante, cons)
`define BPDC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### hw/rtl/bpdc_pkg.sv
// ----------------------------------------------------------------------------
// bpdc_pkg
// widths, register codes, reset values and shared types of the classifier
// ----------------------------------------------------------------------------
`default_nettype none

package bpdc_pkg;

  // field widths
  localparam int unsigned ADC_W      = 12;
  localparam int unsigned MV_W       = 14;
  localparam int unsigned CONF_W     = 8;
  localparam int unsigned SCALE_W    = 18;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned CLS_W      = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 18;
  localparam int unsigned PROD_W     = ADC_W + SCALE_W;
  localparam int unsigned Q_FRAC     = 16;

  // rounding and saturation of the scaled voltage
  localparam logic [PROD_W:0]   ROUND_HALF = (PROD_W + 1)'(32768);
  localparam logic [MV_W-1:0]   MV_MAX     = 14'd16383;

  // linear charge percent: p = ((mv - low) + 4) * 911 >> 13, exact divide by 9
  localparam int unsigned       PCT_Y_W     = 10;
  localparam int unsigned       PCT_P_W     = 2 * PCT_Y_W;
  localparam int unsigned       PCT_SHIFT   = 13;
  localparam logic [MV_W-1:0]   PCT_LOW_MV  = 14'd3300;
  localparam logic [MV_W-1:0]   PCT_HIGH_MV = 14'd4200;
  localparam logic [PCT_Y_W-1:0] PCT_BIAS   = 10'd4;
  localparam logic [PCT_Y_W-1:0] PCT_RECIP  = 10'd911;
  localparam logic [PCT_W-1:0]  PCT_FULL    = 7'd100;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // register reset values
  localparam logic [MV_W-1:0]    RST_ARTIFACT_THR  = 14'd4240;
  localparam logic [MV_W-1:0]    RST_PRESENT_LOW   = 14'd3200;
  localparam logic [MV_W-1:0]    RST_PRESENT_HIGH  = 14'd4180;
  localparam logic [CONF_W-1:0]  RST_ARTIFACT_CONF = 8'd1;
  localparam logic [CONF_W-1:0]  RST_PRESENT_CONF  = 8'd12;
  localparam logic [CONF_W-1:0]  RST_ABSENT_CONF   = 8'd6;
  localparam logic [SCALE_W-1:0] RST_DIVIDER_SCALE = 18'd200428;

  // configuration register index
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ARTIFACT_THR  = 3'd0,
    REG_PRESENT_LOW   = 3'd1,
    REG_PRESENT_HIGH  = 3'd2,
    REG_ARTIFACT_CONF = 3'd3,
    REG_PRESENT_CONF  = 3'd4,
    REG_ABSENT_CONF   = 3'd5,
    REG_DIVIDER_SCALE = 3'd6
  } cfg_reg_e;

  // voltage classes
  typedef enum logic [CLS_W-1:0] {
    CLS_UNKNOWN  = 2'd0,
    CLS_ARTIFACT = 2'd1,
    CLS_PRESENT  = 2'd2,
    CLS_ABSENT   = 2'd3
  } class_e;

  typedef struct packed {
    logic [MV_W-1:0]    artifact_thr;
    logic [MV_W-1:0]    present_low;
    logic [MV_W-1:0]    present_high;
    logic [CONF_W-1:0]  artifact_conf;
    logic [CONF_W-1:0]  present_conf;
    logic [CONF_W-1:0]  absent_conf;
    logic [SCALE_W-1:0] divider_scale;
  } cfg_t;

  // one classified sample from front to back
  typedef struct packed {
    logic [MV_W-1:0] mv;
    class_e          inst;
  } sample_t;

endpackage

`default_nettype wire

### hw/rtl/bpdc_front.sv
// ----------------------------------------------------------------------------
// bpdc_front
// scales the adc sample to battery millivolts and classifies it, two stages
// ----------------------------------------------------------------------------
`default_nettype none

module bpdc_front import bpdc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cfg_t             cfg_i,
  input  wire logic             push_i,
  input  wire logic [ADC_W-1:0] adc_millivolts_i,
  output logic                  full_o,
  input  wire logic             q_full_i,
  output logic                  q_push_o,
  output sample_t               q_data_o
);

  logic              s1_v_q;
  logic [PROD_W-1:0] prod_q;
  logic              s2_v_q;
  sample_t           smp_q;
  logic              s1_rdy;
  logic              s2_rdy;
  logic [PROD_W:0]   rnd_sum;
  logic [PROD_W-Q_FRAC:0] mv_wide;
  logic [MV_W-1:0]   mv;
  class_e            inst;

  // stall chain from the queue back to the input
  assign s2_rdy   = !s2_v_q || !q_full_i;
  assign s1_rdy   = !s1_v_q || s2_rdy;
  assign full_o   = !s1_rdy;
  assign q_push_o = s2_v_q;
  assign q_data_o = smp_q;

  // stage 1: q16 scale multiply
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && push_i) begin
      prod_q <= PROD_W'(adc_millivolts_i) * PROD_W'(cfg_i.divider_scale);
    end
  end

  // round half up, saturate
  always_comb begin
    rnd_sum = {1'b0, prod_q} + ROUND_HALF;
    mv_wide = rnd_sum[PROD_W:Q_FRAC];
    if (mv_wide > (PROD_W - Q_FRAC + 1)'(MV_MAX)) begin
      mv = MV_MAX;
    end else begin
      mv = mv_wide[MV_W-1:0];
    end
  end

  // artifact test first, then the present window
  always_comb begin
    if (mv >= cfg_i.artifact_thr) begin
      inst = CLS_ARTIFACT;
    end else if (mv >= cfg_i.present_low && mv <= cfg_i.present_high) begin
      inst = CLS_PRESENT;
    end else begin
      inst = CLS_ABSENT;
    end
  end

  // stage 2: classified sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_rdy && s1_v_q) begin
      smp_q.mv   <= mv;
      smp_q.inst <= inst;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bpdc_queue.sv
// ----------------------------------------------------------------------------
// bpdc_queue
// short sample queue that decouples the front from the debounce back end
// ----------------------------------------------------------------------------
`default_nettype none

`include "battery_presence_debounce_classifier_unit_macros.svh"

module bpdc_queue import bpdc_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire sample_t data_i,
  output logic         full_o,
  input  wire logic    pop_i,
  output sample_t      data_o,
  output logic         empty_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

  sample_t         mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // checks
  `BPDC_ASSERT_IMPLY(a_cnt_bound, 1'b1, cnt_q <= CntFull)
  `BPDC_ASSERT_IMPLY(a_empty_ptrs, empty_o, rd_ptr_q == wr_ptr_q)
  `BPDC_ASSERT_NEXT(a_push_grows, do_push && !do_pop, cnt_q == $past(cnt_q) + 1'b1)

endmodule

`default_nettype wire

### hw/rtl/bpdc_back.sv
// ----------------------------------------------------------------------------
// bpdc_back
// run counters, stable class update, charge percent and the result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "battery_presence_debounce_classifier_unit_macros.svh"

module bpdc_back import bpdc_pkg::*; #(
  parameter int unsigned RunBits = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire cfg_t         cfg_i,
  input  wire sample_t      q_data_i,
  input  wire logic         q_empty_i,
  output logic              q_pop_o,
  output logic              empty_o,
  input  wire logic         pop_i,
  output logic [CLS_W-1:0]  stable_class_o,
  output logic [CLS_W-1:0]  instant_class_o,
  output logic              bat_detected_o,
  output logic              usb_only_o,
  output logic [PCT_W-1:0]  charge_percent_o,
  output logic [MV_W-1:0]   battery_mv_o
);

  localparam int unsigned CmpW = (RunBits > CONF_W) ? RunBits : CONF_W;
  localparam logic [RunBits-1:0] RunMax = '1;

  logic [RunBits-1:0] art_run_q, pres_run_q, abs_run_q;
  logic [RunBits-1:0] art_run_d, pres_run_d, abs_run_d;
  class_e             stable_q, stable_d;
  logic               take;

  logic               out_v_q;
  class_e             res_stable_q;
  class_e             res_inst_q;
  logic [PCT_W-1:0]   res_pct_q;
  logic [MV_W-1:0]    res_mv_q;

  logic [MV_W-1:0]    pct_diff;
  logic [PCT_Y_W-1:0] pct_y;
  logic [PCT_P_W-1:0] pct_prod;
  logic [PCT_W-1:0]   pct_lin;
  logic [PCT_W-1:0]   pct_d;

  // take a sample when the result slot is free or being drained
  assign take    = !q_empty_i && (!out_v_q || pop_i);
  assign q_pop_o = take;
  assign empty_o = !out_v_q;

  // run counters and class adoption
  always_comb begin
    art_run_d  = '0;
    pres_run_d = '0;
    abs_run_d  = '0;
    stable_d   = stable_q;
    case (q_data_i.inst)
      CLS_ARTIFACT: begin
        art_run_d = (art_run_q == RunMax) ? art_run_q : art_run_q + 1'b1;
        if (CmpW'(art_run_d) >= CmpW'(cfg_i.artifact_conf)) begin
          stable_d = CLS_ARTIFACT;
        end
      end
      CLS_PRESENT: begin
        pres_run_d = (pres_run_q == RunMax) ? pres_run_q : pres_run_q + 1'b1;
        if (CmpW'(pres_run_d) >= CmpW'(cfg_i.present_conf)) begin
          stable_d = CLS_PRESENT;
        end
      end
      default: begin
        abs_run_d = (abs_run_q == RunMax) ? abs_run_q : abs_run_q + 1'b1;
        if (CmpW'(abs_run_d) >= CmpW'(cfg_i.absent_conf)) begin
          stable_d = CLS_ABSENT;
        end
      end
    endcase
  end

  // linear percent, rounded, by reciprocal multiply
  always_comb begin
    pct_diff = q_data_i.mv - PCT_LOW_MV;
    pct_y    = pct_diff[PCT_Y_W-1:0] + PCT_BIAS;
    pct_prod = PCT_P_W'(pct_y) * PCT_P_W'(PCT_RECIP);
    pct_lin  = pct_prod[PCT_SHIFT +: PCT_W];
    if (stable_d != CLS_PRESENT || q_data_i.mv <= PCT_LOW_MV) begin
      pct_d = '0;
    end else if (q_data_i.mv >= PCT_HIGH_MV) begin
      pct_d = PCT_FULL;
    end else begin
      pct_d = pct_lin;
    end
  end

  // debounce state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      art_run_q  <= '0;
      pres_run_q <= '0;
      abs_run_q  <= '0;
      stable_q   <= CLS_UNKNOWN;
    end else if (take) begin
      art_run_q  <= art_run_d;
      pres_run_q <= pres_run_d;
      abs_run_q  <= abs_run_d;
      stable_q   <= stable_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (take) begin
      out_v_q <= 1'b1;
    end else if (pop_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_stable_q <= stable_d;
      res_inst_q   <= q_data_i.inst;
      res_pct_q    <= pct_d;
      res_mv_q     <= q_data_i.mv;
    end
  end

  assign stable_class_o    = res_stable_q;
  assign instant_class_o   = res_inst_q;
  assign bat_detected_o    = (res_stable_q == CLS_PRESENT);
  assign usb_only_o        = (res_stable_q == CLS_ARTIFACT);
  assign charge_percent_o  = res_pct_q;
  assign battery_mv_o      = res_mv_q;

  // checks
  `BPDC_ASSERT_IMPLY(a_one_run, 1'b1, ((art_run_q != '0) + (pres_run_q != '0) + (abs_run_q != '0)) <= 2'd1)
  `BPDC_ASSERT_IMPLY(a_pct_only_present, out_v_q && res_pct_q != '0, res_stable_q == CLS_PRESENT)
  `BPDC_ASSERT_IMPLY(a_pct_range, out_v_q, res_pct_q <= PCT_FULL)
  `BPDC_ASSERT_NEXT(a_stable_sticky, !take, stable_q == $past(stable_q))

endmodule

`default_nettype wire

### hw/rtl/battery_presence_debounce_classifier_unit.sv
// path: an accepted sample passes stage 1, stage 2, the queue and the result register
// throughput: one sample per cycle while full is low; the only loop is the debounce update
// front (multiply, classify) and back (debounce, percent) are split by a 4-entry queue
// reset: asynchronous, clears run counters, stable class (unknown), queue and valids
// reset also loads the default thresholds, confirm counts and divider factor
// ----------------------------------------------------------------------------
// battery_presence_debounce_classifier_unit
// debounced battery presence classifier with linear charge percent
// ----------------------------------------------------------------------------
`default_nettype none

module battery_presence_debounce_classifier_unit import bpdc_pkg::*; #(
  parameter int unsigned RUN_COUNT_BITS = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [ADC_W-1:0]      adc_millivolts_i,
  input  wire logic                  pop,
  output logic                       empty,
  output logic [CLS_W-1:0]           stable_class_o,
  output logic [CLS_W-1:0]           instant_class_o,
  output logic                       bat_detected_o,
  output logic                       usb_only_o,
  output logic [PCT_W-1:0]           charge_percent_o,
  output logic [MV_W-1:0]            battery_mv_o
);

  cfg_t    cfg_q;
  logic    q_push;
  sample_t q_wdata;
  logic    q_full;
  logic    q_pop;
  sample_t q_rdata;
  logic    q_empty;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.artifact_thr  <= RST_ARTIFACT_THR;
      cfg_q.present_low   <= RST_PRESENT_LOW;
      cfg_q.present_high  <= RST_PRESENT_HIGH;
      cfg_q.artifact_conf <= RST_ARTIFACT_CONF;
      cfg_q.present_conf  <= RST_PRESENT_CONF;
      cfg_q.absent_conf   <= RST_ABSENT_CONF;
      cfg_q.divider_scale <= RST_DIVIDER_SCALE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ARTIFACT_THR:  cfg_q.artifact_thr  <= cfg_data_i[MV_W-1:0];
        REG_PRESENT_LOW:   cfg_q.present_low   <= cfg_data_i[MV_W-1:0];
        REG_PRESENT_HIGH:  cfg_q.present_high  <= cfg_data_i[MV_W-1:0];
        REG_ARTIFACT_CONF: cfg_q.artifact_conf <= cfg_data_i[CONF_W-1:0];
        REG_PRESENT_CONF:  cfg_q.present_conf  <= cfg_data_i[CONF_W-1:0];
        REG_ABSENT_CONF:   cfg_q.absent_conf   <= cfg_data_i[CONF_W-1:0];
        REG_DIVIDER_SCALE: cfg_q.divider_scale <= cfg_data_i[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // scale and classify
  bpdc_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .push_i           (push),
    .adc_millivolts_i (adc_millivolts_i),
    .full_o           (full),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .q_data_o         (q_wdata)
  );

  // decoupling queue
  bpdc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  // debounce and result
  bpdc_back #(
    .RunBits (RUN_COUNT_BITS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .q_data_i          (q_rdata),
    .q_empty_i         (q_empty),
    .q_pop_o           (q_pop),
    .empty_o           (empty),
    .pop_i             (pop),
    .stable_class_o    (stable_class_o),
    .instant_class_o   (instant_class_o),
    .bat_detected_o    (bat_detected_o),
    .usb_only_o        (usb_only_o),
    .charge_percent_o  (charge_percent_o),
    .battery_mv_o      (battery_mv_o)
  );

endmodule

`default_nettype wire
